// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the timestamp normalizer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define ATN_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ATN_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/atn_pkg.sv -----
// Shared types, constants and helpers of the timestamp normalizer.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package atn_pkg;
  localparam int TS_W   = 64;
  localparam int GAP_W  = 31;
  localparam int REP_W  = 32;
  localparam int SID_W  = 3;
  localparam int CIDX_W = 2;
  localparam int OP_W   = 4;

  localparam logic [CIDX_W-1:0] CFG_GAP   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_START = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_WIDE  = 2'd2;
  localparam logic [GAP_W-1:0]  GAP_RST   = 31'd5000;

  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd1;
  localparam logic [OP_W-1:0] OP_NULL  = 4'd2;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd3;
  localparam logic [OP_W-1:0] OP_RDK   = 4'd4;
  localparam logic [OP_W-1:0] OP_START = 4'd5;
  localparam logic [OP_W-1:0] OP_STEP  = 4'd6;
  localparam logic [OP_W-1:0] OP_JUMP  = 4'd7;
  localparam logic [OP_W-1:0] OP_LAG   = 4'd8;
  localparam logic [OP_W-1:0] OP_SNAP  = 4'd9;
  localparam logic [OP_W-1:0] OP_REP   = 4'd10;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd11;
  localparam logic [OP_W-1:0] OP_REACH = 4'd12;
  localparam logic [OP_W-1:0] OP_WB    = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan_go;
  } cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_ok;
    logic was_k;
    logic scan_done;
    logic jump;
    logic lag;
    logic out_busy;
  } sts_t;

  function automatic logic sgt(input logic [TS_W-1:0] a, input logic [TS_W-1:0] b);
    return $signed(a) > $signed(b);
  endfunction
endpackage

// ----- rtl/core/av_timestamp_normalizer_top.sv -----
// Top level of the timestamp normalizer: sequencer plus datapath.
// Depends on atn_pkg, atn_ctrl and atn_dpath.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_valid / in_stall  | in_mode, in_stream, in_dts, in_pts
//  out_    | output    | out_valid / out_stall| out_timestamp, out_discontinuity
//  cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// A clear item or an item for a stream index at or above NUM_STREAMS finishes in the
// transfer cycle. A sample for a known stream steps through the sequencer phases; a
// sample can need up to two full scans of the stream tables (a new stream or a jump,
// then a lag), each bounded by the single read port of the stream RAMs.
// Reset is synchronous and active low; it empties all streams and restores the
// register defaults. The input is held only while an item is in work or while a
// finished result sits stalled in the output register.
`timescale 1ns / 1ps
module av_timestamp_normalizer_top #(
  parameter int NUM_STREAMS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [atn_pkg::CIDX_W-1:0] cfg_index,
  input  logic [atn_pkg::TS_W-1:0]   cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [atn_pkg::SID_W-1:0]  in_stream,
  input  logic [atn_pkg::TS_W-1:0]   in_dts,
  input  logic [atn_pkg::TS_W-1:0]   in_pts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [atn_pkg::TS_W-1:0]   out_timestamp,
  output logic                       out_discontinuity
);
  atn_pkg::cmd_t cmd;
  atn_pkg::sts_t sts;

  // The sequencer owns the phase of the current item; all storage is in the datapath.
  atn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .sts(sts), .cmd(cmd),
    .in_stall(in_stall));

  atn_dpath #(.NUM_STREAMS(NUM_STREAMS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_mode(in_mode), .in_stream(in_stream), .in_dts(in_dts), .in_pts(in_pts),
    .out_stall(out_stall), .out_valid(out_valid), .out_timestamp(out_timestamp),
    .out_discontinuity(out_discontinuity));
endmodule

// ----- rtl/core/atn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module atn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/core/atn_ctrl.sv -----
// Sequencer of the timestamp normalizer: steps each item through its phases.
// Depends on atn_pkg; drives commands into atn_dpath and reads its status.
`timescale 1ns / 1ps
module atn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  atn_pkg::sts_t sts,
  output atn_pkg::cmd_t cmd,
  output logic          in_stall
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDA   = 4'd1;
  localparam logic [3:0] S_RDK   = 4'd2;
  localparam logic [3:0] S_SCN   = 4'd3;
  localparam logic [3:0] S_START = 4'd4;
  localparam logic [3:0] S_STEP  = 4'd5;
  localparam logic [3:0] S_SCJ   = 4'd6;
  localparam logic [3:0] S_JUMP  = 4'd7;
  localparam logic [3:0] S_LAG   = 4'd8;
  localparam logic [3:0] S_SCL   = 4'd9;
  localparam logic [3:0] S_SNAP  = 4'd10;
  localparam logic [3:0] S_REP   = 4'd11;
  localparam logic [3:0] S_ADD   = 4'd12;
  localparam logic [3:0] S_REACH = 4'd13;
  localparam logic [3:0] S_WB    = 4'd14;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE) || sts.out_busy;

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = atn_pkg::OP_NONE;
    cmd.scan_go = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          if (sts.in_clear) begin
            cmd.op = atn_pkg::OP_CLEAR;
          end else if (!sts.in_ok) begin
            cmd.op = atn_pkg::OP_NULL;
          end else begin
            cmd.op    = atn_pkg::OP_LOAD;
            state_nxt = S_RDA;
          end
        end
      end
      S_RDA: state_nxt = S_RDK;
      S_RDK: begin
        cmd.op = atn_pkg::OP_RDK;
        if (!sts.was_k) begin
          cmd.scan_go = 1'b1;
          state_nxt   = S_SCN;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_SCN: if (sts.scan_done) state_nxt = S_START;
      S_START: begin
        cmd.op    = atn_pkg::OP_START;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.op = atn_pkg::OP_STEP;
        if (sts.jump) begin
          cmd.scan_go = 1'b1;
          state_nxt   = S_SCJ;
        end else begin
          state_nxt = S_LAG;
        end
      end
      S_SCJ: if (sts.scan_done) state_nxt = S_JUMP;
      S_JUMP: begin
        cmd.op    = atn_pkg::OP_JUMP;
        state_nxt = S_LAG;
      end
      S_LAG: begin
        cmd.op = atn_pkg::OP_LAG;
        if (sts.lag) begin
          cmd.scan_go = 1'b1;
          state_nxt   = S_SCL;
        end else begin
          state_nxt = S_REP;
        end
      end
      S_SCL: if (sts.scan_done) state_nxt = S_SNAP;
      S_SNAP: begin
        cmd.op    = atn_pkg::OP_SNAP;
        state_nxt = S_REP;
      end
      S_REP: begin
        cmd.op    = atn_pkg::OP_REP;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.op    = atn_pkg::OP_ADD;
        state_nxt = S_REACH;
      end
      S_REACH: begin
        cmd.op    = atn_pkg::OP_REACH;
        state_nxt = S_WB;
      end
      S_WB: begin
        if (!sts.out_busy) begin
          cmd.op    = atn_pkg::OP_WB;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ----- rtl/core/atn_dpath.sv -----
// Datapath of the timestamp normalizer: stream tables, scan unit, registers.
// Depends on atn_pkg, atn_ram and assert_macros.svh; commanded by atn_ctrl.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module atn_dpath #(
  parameter int NUM_STREAMS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  atn_pkg::cmd_t                    cmd,
  output atn_pkg::sts_t                    sts,
  input  logic                             cfg_we,
  input  logic [atn_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [atn_pkg::TS_W-1:0]         cfg_wdata,
  input  logic                             in_mode,
  input  logic [atn_pkg::SID_W-1:0]        in_stream,
  input  logic [atn_pkg::TS_W-1:0]         in_dts,
  input  logic [atn_pkg::TS_W-1:0]         in_pts,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [atn_pkg::TS_W-1:0]         out_timestamp,
  output logic                             out_discontinuity
);
  localparam int IW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int W  = atn_pkg::TS_W;
  localparam int RW = atn_pkg::REP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_STREAMS - 1);

  // Configuration.
  logic [atn_pkg::GAP_W-1:0] gap_r;
  logic [W-1:0]              start_r;
  logic                      wide_r;
  logic [W-1:0]              gap64;
  assign gap64 = {{(W - atn_pkg::GAP_W){1'b0}}, gap_r};

  // Per-item working registers.
  logic [IW-1:0] k_r, k_nxt;
  logic [W-1:0]  d_r, d_nxt, p_r, p_nxt;
  logic [W-1:0]  base_r, base_nxt, reach_r, reach_nxt, last_r, last_nxt;
  logic [RW-1:0] rep_r, rep_nxt;
  logic          kval_r, kval_nxt, was_r, was_nxt, disc_r, disc_nxt;
  logic [W-1:0]  diff_r, diff_nxt, ts_r, ts_nxt, off_r, off_nxt;
  logic [W-1:0]  gmax_r, gmax_nxt;
  logic [NUM_STREAMS-1:0] valid_r, valid_nxt;
  logic          oval_r, oval_nxt, odisc_r, odisc_nxt;
  logic [W-1:0]  ots_r, ots_nxt;

  // Scan unit.
  logic          busy_r, busy_nxt, rdv_r, rdv_nxt, found_r, found_nxt;
  logic [IW-1:0] iss_r, iss_nxt, rdi_r, rdi_nxt;
  logic [W-1:0]  max_r, max_nxt, cand_r, cand_nxt, mbase_r, mbase_nxt;

  // Stream tables.
  logic [IW-1:0] raddr;
  logic          wr_en;
  logic [W-1:0]  rd_base, rd_reach, rd_last;
  logic [RW-1:0] rd_rep;

  assign raddr = busy_r ? iss_r : k_r;
  assign wr_en = (cmd.op == atn_pkg::OP_WB);

  atn_ram #(.WIDTH(W), .DEPTH(NUM_STREAMS)) u_base (
    .clk(clk), .we(wr_en), .waddr(k_r), .wdata(base_r), .raddr(raddr), .rdata(rd_base));
  atn_ram #(.WIDTH(W), .DEPTH(NUM_STREAMS)) u_reach (
    .clk(clk), .we(wr_en), .waddr(k_r), .wdata(reach_r), .raddr(raddr), .rdata(rd_reach));
  atn_ram #(.WIDTH(W), .DEPTH(NUM_STREAMS)) u_last (
    .clk(clk), .we(wr_en), .waddr(k_r), .wdata(last_r), .raddr(raddr), .rdata(rd_last));
  atn_ram #(.WIDTH(RW), .DEPTH(NUM_STREAMS)) u_rep (
    .clk(clk), .we(wr_en), .waddr(k_r), .wdata(rep_r), .raddr(raddr), .rdata(rd_rep));

  // Scan element: the entry under update is taken from the working registers.
  logic          e_is_k, e_valid, e_near;
  logic [W-1:0]  e_base, e_reach, e_last, e_dd, e_cand;
  logic [31:0]   e_d32, e_neg;

  always_comb begin
    e_is_k  = (rdi_r == k_r);
    e_valid = e_is_k ? kval_r : valid_r[rdi_r];
    e_base  = e_is_k ? base_r : rd_base;
    e_reach = e_is_k ? reach_r : rd_reach;
    e_last  = e_is_k ? last_r : rd_last;
    e_dd    = d_r - e_last;
    e_d32   = e_dd[31:0];
    e_neg   = 32'd0 - e_d32;
    e_near  = e_d32[31] ? (e_neg < {1'b0, gap_r})
                        : ((e_d32 != 32'd0) && (e_d32 < {1'b0, gap_r}));
    e_cand  = e_base + {{32{e_d32[31]}}, e_d32};
  end

  always_comb begin
    busy_nxt  = busy_r;
    iss_nxt   = iss_r;
    rdv_nxt   = 1'b0;
    rdi_nxt   = iss_r;
    max_nxt   = max_r;
    found_nxt = found_r;
    cand_nxt  = cand_r;
    mbase_nxt = mbase_r;
    if (cmd.scan_go) begin
      busy_nxt  = 1'b1;
      iss_nxt   = '0;
      max_nxt   = start_r;
      found_nxt = 1'b0;
    end else if (busy_r) begin
      rdv_nxt = 1'b1;
      iss_nxt = iss_r + 1'b1;
      if (iss_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end
    end
    // The stream under update always counts toward the maximum: a new stream
    // is not yet marked live when the floor is scanned, and its reach is zero.
    if (rdv_r && (e_valid || e_is_k)) begin
      if (atn_pkg::sgt(e_reach, max_r)) begin
        max_nxt = e_reach;
      end
    end
    if (rdv_r && e_valid) begin
      if (!found_r && e_near && !e_cand[W-1]) begin
        found_nxt = 1'b1;
        cand_nxt  = e_cand;
        mbase_nxt = e_base;
      end
    end
  end

  // Step arithmetic.
  logic [31:0]  l32, d32;
  logic [W-1:0] diffw, diff, step, ts_gap, sum;
  logic         jump, adv, rep_hold;

  always_comb begin
    l32   = last_r[31:0];
    d32   = d_r[31:0] - l32;
    diffw = d_r - last_r;
    if (wide_r) begin
      diff = diffw;
      step = diffw;
      jump = atn_pkg::sgt(diffw, gap64) ||
             (diffw[W-1] && atn_pkg::sgt(last_r - d_r, gap64));
    end else begin
      diff = {{32{d32[31]}}, d32};
      step = {32'd0, d32};
      jump = atn_pkg::sgt(diff, gap64) ||
             (d32[31] && ((l32 - d_r[31:0]) > {1'b0, gap_r}));
    end
    adv      = atn_pkg::sgt(diff, {32'd0, rep_r});
    rep_hold = !disc_r && !atn_pkg::sgt(diff_r, {32'd0, rep_r}) && was_r;
    ts_gap   = ts_r + gap64;
    sum      = ts_r + off_r;
  end

  assign sts.in_clear  = in_mode;
  assign sts.in_ok     = ({4'd0, in_stream} < 7'(NUM_STREAMS));
  assign sts.was_k     = valid_r[k_r];
  assign sts.scan_done = rdv_r && (rdi_r == LAST_IDX);
  assign sts.jump      = jump;
  assign sts.lag       = !atn_pkg::sgt(ts_r, gmax_r) && atn_pkg::sgt(gmax_r, ts_gap);
  assign sts.out_busy  = oval_r && out_stall;

  always_comb begin
    k_nxt = k_r;  d_nxt = d_r;  p_nxt = p_r;
    base_nxt = base_r;  reach_nxt = reach_r;  last_nxt = last_r;  rep_nxt = rep_r;
    kval_nxt = kval_r;  was_nxt = was_r;  disc_nxt = disc_r;
    diff_nxt = diff_r;  ts_nxt = ts_r;  off_nxt = off_r;
    gmax_nxt = gmax_r;  valid_nxt = valid_r;
    oval_nxt = oval_r && out_stall;
    ots_nxt = ots_r;  odisc_nxt = odisc_r;
    case (cmd.op)
      atn_pkg::OP_CLEAR: begin
        valid_nxt = '0;
        gmax_nxt  = '0;
        oval_nxt  = 1'b1;
        ots_nxt   = '0;
        odisc_nxt = 1'b0;
      end
      atn_pkg::OP_NULL: begin
        oval_nxt  = 1'b1;
        ots_nxt   = '0;
        odisc_nxt = 1'b0;
      end
      atn_pkg::OP_LOAD: begin
        k_nxt    = IW'(in_stream);
        d_nxt    = wide_r ? in_dts : {32'd0, in_dts[31:0]};
        p_nxt    = wide_r ? in_pts : {32'd0, in_pts[31:0]};
        disc_nxt = 1'b0;
      end
      atn_pkg::OP_RDK: begin
        kval_nxt  = valid_r[k_r];
        was_nxt   = valid_r[k_r];
        base_nxt  = valid_r[k_r] ? rd_base : '0;
        reach_nxt = valid_r[k_r] ? rd_reach : '0;
        last_nxt  = valid_r[k_r] ? rd_last : '0;
        rep_nxt   = valid_r[k_r] ? rd_rep : '0;
      end
      atn_pkg::OP_START: begin
        kval_nxt  = 1'b1;
        base_nxt  = found_r ? cand_r : max_r;
        reach_nxt = found_r ? mbase_r : max_r;
        last_nxt  = d_r;
      end
      atn_pkg::OP_STEP: begin
        diff_nxt = diff;
        ts_nxt   = base_r;
        if (!jump && adv) begin
          ts_nxt   = base_r + step;
          last_nxt = d_r;
        end
      end
      atn_pkg::OP_JUMP: begin
        base_nxt  = max_r + 64'd1;
        reach_nxt = max_r + 64'd1;
        ts_nxt    = max_r + 64'd1;
        last_nxt  = d_r;
        rep_nxt   = '0;
        disc_nxt  = 1'b1;
      end
      atn_pkg::OP_LAG: begin
        if (atn_pkg::sgt(ts_r, gmax_r)) begin
          gmax_nxt = ts_r;
        end
      end
      atn_pkg::OP_SNAP: begin
        ts_nxt   = max_r;
        last_nxt = d_r;
      end
      atn_pkg::OP_REP: begin
        base_nxt = ts_r;
        if (rep_hold) begin
          rep_nxt = (rep_r == {RW{1'b1}}) ? rep_r : rep_r + 1'b1;
        end else begin
          rep_nxt = '0;
        end
      end
      atn_pkg::OP_ADD: begin
        ts_nxt  = ts_r + {32'd0, rep_r};
        off_nxt = wide_r ? (p_r - d_r) : {32'd0, p_r[31:0] - d_r[31:0]};
      end
      atn_pkg::OP_REACH: begin
        if (atn_pkg::sgt(sum, ts_r)) begin
          if (atn_pkg::sgt(sum, reach_r)) reach_nxt = sum;
        end else if (atn_pkg::sgt(ts_r, reach_r)) begin
          reach_nxt = ts_r;
        end
      end
      atn_pkg::OP_WB: begin
        valid_nxt[k_r] = 1'b1;
        oval_nxt       = 1'b1;
        ots_nxt        = ts_r;
        odisc_nxt      = disc_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r   <= atn_pkg::GAP_RST;
      start_r <= '0;
      wide_r  <= 1'b0;
      valid_r <= '0;
      gmax_r  <= '0;
      oval_r  <= 1'b0;
      busy_r  <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          atn_pkg::CFG_GAP:   gap_r   <= cfg_wdata[atn_pkg::GAP_W-1:0];
          atn_pkg::CFG_START: start_r <= cfg_wdata;
          atn_pkg::CFG_WIDE:  wide_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      valid_r <= valid_nxt;
      gmax_r  <= gmax_nxt;
      oval_r  <= oval_nxt;
      busy_r  <= busy_nxt;
      rdv_r   <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;  d_r <= d_nxt;  p_r <= p_nxt;
    base_r <= base_nxt;  reach_r <= reach_nxt;  last_r <= last_nxt;  rep_r <= rep_nxt;
    kval_r <= kval_nxt;  was_r <= was_nxt;  disc_r <= disc_nxt;
    diff_r <= diff_nxt;  ts_r <= ts_nxt;  off_r <= off_nxt;
    ots_r <= ots_nxt;  odisc_r <= odisc_nxt;
    iss_r <= iss_nxt;  rdi_r <= rdi_nxt;
    max_r <= max_nxt;  found_r <= found_nxt;  cand_r <= cand_nxt;  mbase_r <= mbase_nxt;
  end

  assign out_valid         = oval_r;
  assign out_timestamp     = ots_r;
  assign out_discontinuity = odisc_r;

  `ATN_ASSERT_IMP(a_scan_idx, clk, rst_n, rdv_r, rdi_r <= LAST_IDX, "scan index overran")
  `ATN_ASSERT_NXT(a_wb_valid, clk, rst_n, cmd.op == atn_pkg::OP_WB, valid_r[$past(k_r)], "stream not marked valid after write-back")
  `ATN_ASSERT_NXT(a_gmax_mono, clk, rst_n, cmd.op != atn_pkg::OP_CLEAR, $signed(gmax_r) >= $signed($past(gmax_r)), "global maximum decreased")
endmodule

// ----- verif/av_timestamp_normalizer_top_test.sv -----
// Self-checking testbench for the timestamp normalizer top level.
// Depends on atn_pkg and av_timestamp_normalizer_top; predicts every transfer in-line.
`timescale 1ns / 1ps
module av_timestamp_normalizer_top_test;
  localparam int NSTR = 8;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [atn_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [atn_pkg::TS_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [atn_pkg::SID_W-1:0] in_stream = '0;
  logic [atn_pkg::TS_W-1:0] in_dts = '0;
  logic [atn_pkg::TS_W-1:0] in_pts = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [atn_pkg::TS_W-1:0] out_timestamp;
  logic out_discontinuity;

  av_timestamp_normalizer_top #(.NUM_STREAMS(NSTR)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_stream(in_stream), .in_dts(in_dts), .in_pts(in_pts),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_timestamp(out_timestamp), .out_discontinuity(out_discontinuity)
  );

  // The clock period is 2 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The predictor keeps its own mirror of the stream tables and registers.
  logic [63:0] tl_base [NSTR];
  logic [63:0] tl_reached [NSTR];
  logic [63:0] tl_last [NSTR];
  logic        tl_live [NSTR];
  logic [31:0] tl_rep [NSTR];
  logic [63:0] tl_max;
  logic [30:0] reg_gap;
  logic [63:0] reg_start;
  logic        reg_wide;

  typedef struct packed {
    logic [63:0] timestamp;
    logic        disc;
  } mapped_t;

  mapped_t mapped_q[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int disc_seen = 0;
  longint unsigned cycles = 0;
  bit stall_long = 1'b0;

  function automatic logic gt_s(logic [63:0] a, logic [63:0] b);
    return $signed(a) > $signed(b);
  endfunction

  function automatic logic [63:0] ext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] timeline_floor();
    logic [63:0] m;
    m = reg_start;
    for (int i = 0; i < NSTR; i++)
      if (tl_live[i] && gt_s(tl_reached[i], m)) m = tl_reached[i];
    return m;
  endfunction

  function automatic void wipe_streams();
    for (int i = 0; i < NSTR; i++) begin
      tl_base[i] = '0;
      tl_reached[i] = '0;
      tl_last[i] = '0;
      tl_live[i] = 1'b0;
      tl_rep[i] = '0;
    end
    tl_max = '0;
  endfunction

  // A stream seen for the first time aligns to a nearby live stream, or else
  // starts at the floor: the highest reach of any live stream, or the start time.
  function automatic void open_stream(int s, logic [63:0] d);
    logic [31:0] d32;
    logic near;
    logic [63:0] cand;
    for (int i = 0; i < NSTR; i++) begin
      if (tl_live[i]) begin
        d32 = 32'(d - tl_last[i]);
        if (d32[31]) near = {32'd0, 32'(32'd0 - d32)} < {33'd0, reg_gap};
        else near = (d32 != 0) && ({32'd0, d32} < {33'd0, reg_gap});
        cand = tl_base[i] + ext32(d32);
        if (near && !cand[63]) begin
          tl_live[s] = 1'b1;
          tl_base[s] = cand;
          tl_reached[s] = tl_base[i];
          tl_last[s] = d;
          return;
        end
      end
    end
    tl_live[s] = 1'b1;
    tl_base[s] = timeline_floor();
    tl_reached[s] = tl_base[s];
    tl_last[s] = d;
  endfunction

  function automatic mapped_t map_sample(logic mode, logic [2:0] sid, logic [63:0] dts_in,
                                         logic [63:0] pts_in);
    mapped_t r;
    logic [63:0] d, p, ts, diff, step, off, c, last, g;
    logic [31:0] l32, d32;
    logic was, jump, disc;
    int k;
    r = '0;
    if (mode) begin
      wipe_streams();
      return r;
    end
    k = sid;
    g = {33'd0, reg_gap};
    d = reg_wide ? dts_in : {32'd0, dts_in[31:0]};
    p = reg_wide ? pts_in : {32'd0, pts_in[31:0]};
    disc = 1'b0;
    was = tl_live[k];
    if (!was) open_stream(k, d);
    ts = tl_base[k];
    last = tl_last[k];
    if (reg_wide) begin
      diff = d - last;
      step = diff;
      jump = gt_s(diff, g) || (diff[63] && gt_s(last - d, g));
    end else begin
      l32 = last[31:0];
      d32 = d[31:0] - l32;
      diff = ext32(d32);
      step = {32'd0, d32};
      jump = gt_s(diff, g) || (d32[31] && ({32'd0, 32'(l32 - d[31:0])} > g));
    end
    if (jump) begin
      tl_base[k] = timeline_floor() + 64'd1;
      tl_reached[k] = tl_base[k];
      tl_last[k] = d;
      tl_rep[k] = '0;
      disc = 1'b1;
      ts = tl_base[k];
    end else if (gt_s(diff, {32'd0, tl_rep[k]})) begin
      ts = tl_base[k] + step;
      tl_last[k] = d;
    end
    if (gt_s(ts, tl_max)) tl_max = ts;
    else if (gt_s(tl_max, ts + g)) begin
      ts = timeline_floor();
      tl_last[k] = d;
    end
    tl_base[k] = ts;
    if (!disc && !gt_s(diff, {32'd0, tl_rep[k]}) && was) begin
      if (tl_rep[k] != 32'hFFFF_FFFF) tl_rep[k]++;
    end else begin
      tl_rep[k] = '0;
    end
    ts += {32'd0, tl_rep[k]};
    off = reg_wide ? (p - d) : {32'd0, 32'(p - d)};
    c = ts;
    if (gt_s(ts + off, c)) c = ts + off;
    if (gt_s(c, tl_reached[k])) tl_reached[k] = c;
    r.timestamp = ts;
    r.disc = disc;
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // One transfer on the input channel; the prediction is made when it is accepted.
  // The task starts and ends at a falling edge; valid stays high into the next item
  // when there is no gap, and the gap or a drain drops it.
  task automatic send_item(logic mode, logic [2:0] sid, logic [63:0] d, logic [63:0] p);
    int idle;
    idle = gap_len();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_stream <= sid;
    in_dts <= d;
    in_pts <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mapped_q.push_back(map_sample(mode, sid, d, p));
    sent++;
    @(negedge clk);
  endtask

  // Registers change only with nothing in flight: the task first waits until
  // every predicted result has arrived, and then idles before the write.
  task automatic write_reg(logic [atn_pkg::CIDX_W-1:0] idx, logic [63:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      atn_pkg::CFG_GAP: reg_gap = value[30:0];
      atn_pkg::CFG_START: reg_start = value;
      atn_pkg::CFG_WIDE: reg_wide = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mapped_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Result side: random stall pattern and the comparison against the oldest prediction.
  always @(negedge clk) begin
    if (stall_long) out_stall <= ($urandom_range(0, 3) != 0);
    else out_stall <= ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 60) == 0) stall_long <= ~stall_long;
  end

  always @(posedge clk) begin
    mapped_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      received++;
      if (mapped_q.size() == 0) begin
        $error("unexpected transfer: timestamp %h", out_timestamp);
        errors++;
      end else begin
        want = mapped_q.pop_front();
        if (out_timestamp !== want.timestamp) begin
          $error("timestamp: expected %h actual %h", want.timestamp, out_timestamp);
          errors++;
        end
        if (out_discontinuity !== want.disc) begin
          $error("discontinuity: expected %b actual %b", want.disc, out_discontinuity);
          errors++;
        end
        if (want.disc) disc_seen++;
      end
    end
  end

  // Directed checks of field extremes, clears, jumps, rewinds, repeats and alignment.
  task automatic test_directed();
    send_item(1'b0, 3'd0, 64'd1000, 64'd1100);
    send_item(1'b0, 3'd0, 64'd1000, 64'd1000);
    send_item(1'b0, 3'd0, 64'd1000, 64'd900);
    send_item(1'b0, 3'd0, 64'd1010, 64'd1050);
    send_item(1'b0, 3'd1, 64'd1020, 64'd1020);
    send_item(1'b0, 3'd0, 64'd90000, 64'd90000);
    send_item(1'b0, 3'd0, 64'd10, 64'd10);
    send_item(1'b0, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_item(1'b0, 3'd7, 64'h0000_0000_7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(1'b0, 3'd2, 64'd0, 64'd0);
    send_item(1'b1, 3'd5, rand64(), rand64());
    send_item(1'b0, 3'd3, 64'd500, 64'd400);
    send_item(1'b0, 3'd3, 64'd400, 64'd400);
  endtask

  task automatic test_wide_mode();
    write_reg(atn_pkg::CFG_WIDE, 64'd1);
    write_reg(atn_pkg::CFG_START, SIGN64);
    send_item(1'b1, 3'd0, '0, '0);
    send_item(1'b0, 3'd4, SIGN64, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(1'b0, 3'd4, 64'h7FFF_FFFF_FFFF_FFFF, SIGN64);
    send_item(1'b0, 3'd5, 64'hFFFF_FFFF_FFFF_FF00, 64'd0);
    send_item(1'b0, 3'd5, 64'hFFFF_FFFF_FFFF_FF10, 64'd5);
    send_item(1'b0, 3'd5, 64'hFFFF_FFFF_FFFF_FF10, 64'd5);
    write_reg(atn_pkg::CFG_START, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(1'b1, 3'd0, '0, '0);
    send_item(1'b0, 3'd6, 64'd1, 64'd2);
    send_item(1'b0, 3'd6, 64'd2, 64'd2);
  endtask

  // Random phases: mostly small steps on a few streams, with jumps, rewinds,
  // repeats, clears and raw noise mixed in, under varying register settings.
  task automatic test_random_phase(int count, logic [30:0] g, logic wide, logic [63:0] st);
    logic [63:0] cur [NSTR];
    int sid, pick;
    logic [63:0] d, p;
    write_reg(atn_pkg::CFG_GAP, {33'd0, g});
    write_reg(atn_pkg::CFG_WIDE, {63'd0, wide});
    write_reg(atn_pkg::CFG_START, st);
    for (int i = 0; i < NSTR; i++) cur[i] = rand64() >> $urandom_range(8, 40);
    for (int n = 0; n < count; n++) begin
      sid = $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      if (pick < 60) cur[sid] += $urandom_range(0, (g > 40) ? 40 : g + 1);
      else if (pick < 70) cur[sid] = cur[sid];
      else if (pick < 78) cur[sid] -= $urandom_range(0, 60);
      else if (pick < 84) cur[sid] += {33'd0, g} + $urandom_range(1, 1000);
      else if (pick < 88) cur[sid] -= {33'd0, g} + $urandom_range(1, 1000);
      else if (pick < 90) cur[sid] = cur[(sid + 1) % NSTR] + $urandom_range(0, 3);
      else if (pick < 97) cur[sid] = rand64();
      d = cur[sid];
      p = ($urandom_range(0, 4) == 0) ? rand64() : d + $urandom_range(0, 200) - 50;
      send_item(pick >= 97 && $urandom_range(0, 1) == 0, 3'(sid), d, p);
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    reg_gap = atn_pkg::GAP_RST;
    reg_start = '0;
    reg_wide = 1'b0;
    wipe_streams();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_wide_mode();
    test_random_phase(130, 31'd5000, 1'b0, 64'd0);
    test_random_phase(110, 31'd0, 1'b1, SIGN64);
    test_random_phase(110, 31'h7FFF_FFFF, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF);
    test_random_phase(100, 31'd30, 1'b1, rand64());
    test_random_phase(80, 31'd2, 1'b0, 64'd100);
    wait_drained();
    $display("Covered %0d transfers in, %0d out, %0d discontinuities,", sent, received,
             disc_seen);
    $display("both dts modes and gap and start_time extremes.");
    if (errors == 0 && mapped_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/atn_pkg.sv
rtl/core/atn_ram.sv
rtl/core/atn_ctrl.sv
rtl/core/atn_dpath.sv
rtl/core/av_timestamp_normalizer_top.sv
verif/av_timestamp_normalizer_top_test.sv
